// ===== design/pfd_pkg.sv =====
`timescale 1ns / 1ps

package pfd_pkg;

    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int VAL_W      = 32;
    localparam int TIME_W     = 20;
    localparam int INTERVAL_W = 16;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10;

    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;
    localparam int PIXEL_BITS_DEF   = 32;

    // depth of the queue between front and back, and of the result queue
    localparam int IQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;

    typedef struct packed {
        logic [X_W-1:0]    pos_x;
        logic [Y_W-1:0]    pos_y;
        logic [VAL_W-1:0]  pixel_value;
        logic [TIME_W-1:0] time_mark;
        logic              in_frame;
    } pfd_item_t;

    typedef struct packed {
        logic [X_W-1:0] out_x;
        logic [Y_W-1:0] out_y;
        logic           changed;
        logic           flicker;
    } pfd_result_t;

endpackage

// ===== design/pfd_ram.sv =====
`timescale 1ns / 1ps

module pfd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pfd_front.sv =====
`timescale 1ns / 1ps

module pfd_front import pfd_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int ADDR_W       = 19
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              init_done,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [X_W-1:0]    s_pos_x,
    input  logic [Y_W-1:0]    s_pos_y,
    input  logic [VAL_W-1:0]  s_pixel_value,
    input  logic [TIME_W-1:0] s_time_mark,
    output logic              q_valid,
    output pfd_item_t         q_item,
    output logic [ADDR_W-1:0] q_addr,
    input  logic              q_pop
);

    localparam int QA_W = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
    localparam int QC_W = $clog2(IQ_DEPTH + 1);

    pfd_item_t         item_mem_reg [IQ_DEPTH];
    logic [ADDR_W-1:0] addr_mem_reg [IQ_DEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;

    pfd_item_t         in_item;
    logic [ADDR_W-1:0] in_addr;
    logic              push;

    // classify: inside the frame, and the linear pixel address
    always_comb begin
        in_item.pos_x       = s_pos_x;
        in_item.pos_y       = s_pos_y;
        in_item.pixel_value = s_pixel_value;
        in_item.time_mark   = s_time_mark;
        in_item.in_frame    = (32'(s_pos_x) < 32'(FRAME_WIDTH)) &&
                              (32'(s_pos_y) < 32'(FRAME_HEIGHT));
        if (in_item.in_frame) begin
            in_addr = ADDR_W'(32'(s_pos_y) * 32'(FRAME_WIDTH) + 32'(s_pos_x));
        end else begin
            in_addr = '0;
        end
    end

    assign s_ready = init_done && (count_reg != QC_W'(IQ_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = item_mem_reg[rd_ptr_reg];
    assign q_addr  = addr_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == IQ_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == IQ_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_mem_reg[wr_ptr_reg] <= in_item;
            addr_mem_reg[wr_ptr_reg] <= in_addr;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !push)
        else $error("transaction accepted during clearing pass");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QC_W'(IQ_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== design/pfd_back.sv =====
`timescale 1ns / 1ps

module pfd_back import pfd_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int PIXEL_BITS   = PIXEL_BITS_DEF,
    parameter int ADDR_W       = 19
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [INTERVAL_W-1:0] flicker_interval,
    output logic                  init_done,
    input  logic                  q_valid,
    input  pfd_item_t             q_item,
    input  logic [ADDR_W-1:0]     q_addr,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pfd_result_t           m_result
);

    localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ENTRY_W   = TIME_W + PIXEL_BITS;
    localparam int OA_W      = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int OC_W      = $clog2(OQ_DEPTH + 1);

    // clearing pass
    logic              init_done_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // judge stage
    logic              s1_valid_reg;
    pfd_item_t         s1_item_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // last store write, for a read that raced it
    logic               wr_valid_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [ENTRY_W-1:0] wr_data_reg;

    // result queue
    pfd_result_t     oq_mem_reg [OQ_DEPTH];
    logic [OA_W-1:0] oq_wr_ptr_reg;
    logic [OA_W-1:0] oq_rd_ptr_reg;
    logic [OC_W-1:0] oq_count_reg, oq_count_next;

    logic [ENTRY_W-1:0]    ram_rdata;
    logic [ENTRY_W-1:0]    entry;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  item_write;
    logic [PIXEL_BITS-1:0] old_val;
    logic [PIXEL_BITS-1:0] new_val;
    logic [TIME_W-1:0]     last_mark;
    logic [TIME_W-1:0]     new_mark;
    logic [TIME_W-1:0]     elapsed;
    logic                  recent;
    logic                  changed;
    logic                  flicker;
    pfd_result_t           s1_result;
    logic                  oq_push;
    logic                  oq_pop;
    logic [OC_W:0]         in_flight;

    assign init_done = init_done_reg;

    // issue only with room in the result queue, so the judge stage never stalls
    assign in_flight = (OC_W + 1)'(oq_count_reg) + (OC_W + 1)'(s1_valid_reg);
    assign q_pop     = q_valid && init_done_reg &&
                       (in_flight < (OC_W + 1)'(OQ_DEPTH));

    pfd_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (PIX_COUNT),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) begin
            entry = wr_data_reg;
        end else begin
            entry = ram_rdata;
        end
        old_val   = entry[PIXEL_BITS-1:0];
        last_mark = entry[ENTRY_W-1:PIXEL_BITS];
        new_val   = s1_item_reg.pixel_value[PIXEL_BITS-1:0];
        elapsed   = s1_item_reg.time_mark - last_mark;
        // a wrapped time mark counts as long ago
        recent    = (last_mark != '0) && (s1_item_reg.time_mark >= last_mark) &&
                    (elapsed < TIME_W'(flicker_interval));
        changed   = s1_item_reg.in_frame && (old_val != new_val);
        new_mark  = last_mark;
        flicker   = 1'b0;
        if (flicker_interval == '0) begin
            flicker = changed;
        end else if (changed) begin
            flicker  = recent;
            new_mark = s1_item_reg.time_mark;
        end else if (last_mark != '0 && !recent) begin
            new_mark = '0;
        end

        item_write = s1_valid_reg && s1_item_reg.in_frame;
        if (!init_done_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = item_write;
            ram_waddr = s1_addr_reg;
            ram_wdata = {new_mark, new_val};
        end

        s1_result.out_x   = s1_item_reg.pos_x;
        s1_result.out_y   = s1_item_reg.pos_y;
        s1_result.changed = changed;
        s1_result.flicker = flicker;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_done_reg <= 1'b0;
            clr_addr_reg  <= '0;
        end else if (!init_done_reg) begin
            if (clr_addr_reg == ADDR_W'(PIX_COUNT - 1)) begin
                init_done_reg <= 1'b1;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= q_pop;
            wr_valid_reg <= init_done_reg && item_write;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_item_reg <= q_item;
            s1_addr_reg <= q_addr;
        end
        wr_addr_reg <= s1_addr_reg;
        wr_data_reg <= ram_wdata;
    end

    assign oq_push  = s1_valid_reg;
    assign oq_pop   = m_valid && m_ready;
    assign m_valid  = (oq_count_reg != '0);
    assign m_result = oq_mem_reg[oq_rd_ptr_reg];

    always_comb begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop) begin
            oq_count_next = oq_count_reg + 1'b1;
        end else if (!oq_push && oq_pop) begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end else begin
            oq_count_reg <= oq_count_next;
            if (oq_push) begin
                oq_wr_ptr_reg <= (32'(oq_wr_ptr_reg) == OQ_DEPTH - 1) ?
                                 '0 : oq_wr_ptr_reg + 1'b1;
            end
            if (oq_pop) begin
                oq_rd_ptr_reg <= (32'(oq_rd_ptr_reg) == OQ_DEPTH - 1) ?
                                 '0 : oq_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (oq_push) begin
            oq_mem_reg[oq_wr_ptr_reg] <= s1_result;
        end
    end

    a_oq_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        oq_push |-> (oq_count_reg != OC_W'(OQ_DEPTH)) || oq_pop)
        else $error("result queue overflow");

    a_flicker_needs_change: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> !(flicker && !changed))
        else $error("flicker flagged on unchanged pixel");

    a_clear_before_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $past(init_done_reg))
        else $error("item issued before clearing pass finished");

endmodule

// ===== design/pixel_flicker_detector_top.sv =====
`timescale 1ns / 1ps

// Pixel flicker detector. Each transaction is one framebuffer pixel write and
// yields one result: the position echoed, whether the value changed, and
// whether the change came within flicker_interval milliseconds of the pixel's
// last change. One transaction per cycle is sustained while m_ready stays high;
// the rate is set by the single read-modify-write port pair of the per-pixel
// store, with the last write forwarded to a read that races it. A transaction
// passes through the input queue, the judge stage and the result queue. After
// reset the store is cleared one pixel per cycle, and s_ready stays low until
// the clearing pass is done; cfg writes are taken at any time.
module pixel_flicker_detector_top import pfd_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    parameter int PIXEL_BITS   = PIXEL_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [X_W-1:0]        s_pos_x,
    input  logic [Y_W-1:0]        s_pos_y,
    input  logic [VAL_W-1:0]      s_pixel_value,
    input  logic [TIME_W-1:0]     s_time_mark,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [X_W-1:0]        m_out_x,
    output logic [Y_W-1:0]        m_out_y,
    output logic                  m_changed,
    output logic                  m_flicker,
    input  logic                  cfg_wr_en,
    input  logic [INTERVAL_W-1:0] cfg_wr_data
);

    localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;

    logic [INTERVAL_W-1:0] interval_reg;
    logic                  init_done;
    logic                  q_valid;
    pfd_item_t             q_item;
    logic [ADDR_W-1:0]     q_addr;
    logic                  q_pop;
    pfd_result_t           m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            interval_reg <= cfg_wr_data;
        end
    end

    pfd_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .init_done     (init_done),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pixel_value (s_pixel_value),
        .s_time_mark   (s_time_mark),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_addr        (q_addr),
        .q_pop         (q_pop)
    );

    pfd_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .PIXEL_BITS   (PIXEL_BITS),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .flicker_interval (interval_reg),
        .init_done        (init_done),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_addr           (q_addr),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result         (m_result)
    );

    assign m_out_x   = m_result.out_x;
    assign m_out_y   = m_result.out_y;
    assign m_changed = m_result.changed;
    assign m_flicker = m_result.flicker;

endmodule
